// ----- src/eihf_pkg.sv -----
// Package for the Ethernet/VLAN/IPv4 header filter.
// Holds verdict codes, frame kinds, register indexes and the frame summary type.
package eihf_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] VERDICT_IP_OK       = 4'd0;
    localparam logic [3:0] VERDICT_OTHER       = 4'd1;
    localparam logic [3:0] VERDICT_SHORT       = 4'd2;
    localparam logic [3:0] VERDICT_VLAN_SHORT  = 4'd3;
    localparam logic [3:0] VERDICT_VLAN_OFF    = 4'd4;
    localparam logic [3:0] VERDICT_VLAN_MISS   = 4'd5;
    localparam logic [3:0] VERDICT_IP_SHORT    = 4'd6;
    localparam logic [3:0] VERDICT_IP_LEN      = 4'd7;
    localparam logic [3:0] VERDICT_NOT_V4      = 4'd8;
    localparam logic [3:0] VERDICT_OPTIONS     = 4'd9;
    localparam logic [3:0] VERDICT_BAD_SUM     = 4'd10;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_SNAP  = 2'd1;
    localparam logic [1:0] KIND_VLAN  = 2'd2;

    localparam logic REG_OUR_VLAN    = 1'b0;
    localparam logic REG_NATIVE_VLAN = 1'b1;

    localparam logic [11:0] NO_VLAN   = 12'hFFF;
    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] SNAP_LIMIT = 16'd1514;

    // Frame summary handed from the front part to the back part.
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] type_word;
        logic [11:0] tag_id;
        logic [1:0]  kind;
        logic [7:0]  ver_len;
        logic [15:0] total_len;
        logic        sum_good;
    } frame_sum_t;

endpackage

// ----- src/eihf_front.sv -----
// Front part: collects header fields of a frame one item per cycle while take is high.
// Depends on eihf_pkg; emits one frame summary at the last item.
module eihf_front #(
    parameter int COUNT_BITS = eihf_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           frame_byte,
    input  logic                 last_byte,
    output logic                 sum_valid,
    output eihf_pkg::frame_sum_t sum_out
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_reg;
    logic [15:0] type_reg;
    logic [15:0] tag_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  vl_reg;
    logic [15:0] tl_reg;
    logic [19:0] acc_reg;
    logic [7:0]  hold_reg;

    logic [COUNT_BITS-1:0] count_next;
    logic [15:0] type_next;
    logic [15:0] tag_next;
    logic [1:0]  kind_next;
    logic [7:0]  vl_next;
    logic [15:0] tl_next;
    logic [19:0] acc_next;
    logic [7:0]  hold_next;
    logic [15:0] pos;
    logic [15:0] off;
    logic [15:0] rel;
    logic [15:0] full_type;
    logic [19:0] fold1;
    logic [16:0] fold2;
    logic [15:0] fold3;

    assign pos = 16'(count_reg);
    assign off = (kind_reg == eihf_pkg::KIND_SNAP) ? 16'd22 :
                 (kind_reg == eihf_pkg::KIND_VLAN) ? 16'd18 : 16'd14;
    assign rel = pos - off;
    assign full_type = {type_reg[15:8], frame_byte};

    // Advance the per-frame header state
    always_comb
    begin
        type_next = type_reg;
        tag_next  = tag_reg;
        kind_next = kind_reg;
        vl_next   = vl_reg;
        tl_next   = tl_reg;
        acc_next  = acc_reg;
        hold_next = hold_reg;
        if (pos == 16'd12)
        begin
            type_next = {frame_byte, 8'h00};
        end
        else if (pos == 16'd13)
        begin
            if (full_type < eihf_pkg::SNAP_LIMIT)
            begin
                kind_next = eihf_pkg::KIND_SNAP;
                type_next = 16'h0000;
            end
            else if (full_type == eihf_pkg::TYPE_VLAN)
            begin
                kind_next = eihf_pkg::KIND_VLAN;
                type_next = 16'h0000;
            end
            else
            begin
                kind_next = eihf_pkg::KIND_PLAIN;
                type_next = full_type;
            end
        end
        else if (pos >= 16'd14)
        begin
            if (pos == 16'd14)
                tag_next = {frame_byte, 8'h00};
            else if (pos == 16'd15)
                tag_next = {tag_reg[15:8], frame_byte};
            if ((kind_reg == eihf_pkg::KIND_VLAN && pos == 16'd16) ||
                (kind_reg == eihf_pkg::KIND_SNAP && pos == 16'd20))
                type_next = {frame_byte, 8'h00};
            else if ((kind_reg == eihf_pkg::KIND_VLAN && pos == 16'd17) ||
                     (kind_reg == eihf_pkg::KIND_SNAP && pos == 16'd21))
                type_next = {type_reg[15:8], frame_byte};
            if (pos >= off && rel < 16'd20)
            begin
                if (rel == 16'd0)
                    vl_next = frame_byte;
                else if (rel == 16'd2)
                    tl_next = {frame_byte, 8'h00};
                else if (rel == 16'd3)
                    tl_next = {tl_reg[15:8], frame_byte};
                if (!rel[0])
                    hold_next = frame_byte;
                else
                    acc_next = acc_reg + {4'h0, hold_reg, frame_byte};
            end
        end
        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : COUNT_MAX;
    end

    // Fold the checksum with the final update included
    always_comb
    begin
        fold1 = {4'h0, acc_next[15:0]} + {16'h0, acc_next[19:16]};
        fold2 = {1'b0, fold1[15:0]} + {13'h0, fold1[19:16]};
        fold3 = fold2[15:0];
    end

    // Hold state; clear it at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            type_reg  <= '0;
            tag_reg   <= '0;
            kind_reg  <= eihf_pkg::KIND_PLAIN;
            vl_reg    <= '0;
            tl_reg    <= '0;
            acc_reg   <= '0;
            hold_reg  <= '0;
            sum_valid <= 1'b0;
        end
        else
        begin
            sum_valid <= take && last_byte;
            if (take)
            begin
                if (last_byte)
                begin
                    count_reg <= '0;
                    type_reg  <= '0;
                    tag_reg   <= '0;
                    kind_reg  <= eihf_pkg::KIND_PLAIN;
                    vl_reg    <= '0;
                    tl_reg    <= '0;
                    acc_reg   <= '0;
                    hold_reg  <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                    type_reg  <= type_next;
                    tag_reg   <= tag_next;
                    kind_reg  <= kind_next;
                    vl_reg    <= vl_next;
                    tl_reg    <= tl_next;
                    acc_reg   <= acc_next;
                    hold_reg  <= hold_next;
                end
            end
        end
    end

    // Register the frame summary
    always_ff @(posedge clk)
    begin
        if (take && last_byte)
        begin
            sum_out.len       <= 16'(count_next);
            sum_out.type_word <= type_next;
            sum_out.tag_id    <= tag_next[11:0];
            sum_out.kind      <= kind_next;
            sum_out.ver_len   <= vl_next;
            sum_out.total_len <= tl_next;
            sum_out.sum_good  <= (fold3 == 16'h0000) || (fold3 == 16'hFFFF);
        end
    end

endmodule

// ----- src/eihf_back.sv -----
// Back part: queues frame summaries and turns each into a verdict item.
// Depends on eihf_pkg; the result queue drives the output ports.
module eihf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sum_valid,
    input  eihf_pkg::frame_sum_t sum_in,
    input  logic [15:0]          our_vlan,
    input  logic [15:0]          native_vlan,
    input  logic                 pop,
    output logic                 empty,
    output logic                 almost_full,
    output logic [3:0]           verdict,
    output logic [15:0]          ether_type,
    output logic [11:0]          vlan_number,
    output logic [4:0]           payload_offset,
    output logic [15:0]          ip_length
);

    localparam int DEPTH = eihf_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = 4 + 16 + 12 + 5 + 16;

    logic [RW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   cnt_reg;
    logic [3:0]  v;
    logic [15:0] t;
    logic [11:0] vid;
    logic [4:0]  o;
    logic [15:0] il;
    logic        active;
    logic        do_pop;
    logic [16:0] need_min;
    logic [16:0] need_tl;

    assign active = our_vlan[11:0] != eihf_pkg::NO_VLAN;

    // Work out the verdict from the summary
    always_comb
    begin
        v   = eihf_pkg::VERDICT_OTHER;
        t   = 16'h0000;
        vid = eihf_pkg::NO_VLAN;
        o   = 5'd14;
        il  = 16'h0000;
        need_min = 17'd0;
        need_tl  = 17'd0;
        if (sum_in.len < 16'd14)
        begin
            v = eihf_pkg::VERDICT_SHORT;
        end
        else
        begin
            o = (sum_in.kind == eihf_pkg::KIND_SNAP) ? 5'd22 :
                (sum_in.kind == eihf_pkg::KIND_VLAN) ? 5'd18 : 5'd14;
            if (sum_in.kind == eihf_pkg::KIND_VLAN && sum_in.len < 16'd18)
            begin
                v = eihf_pkg::VERDICT_VLAN_SHORT;
                t = eihf_pkg::TYPE_VLAN;
            end
            else if (sum_in.kind == eihf_pkg::KIND_VLAN && !active)
            begin
                v = eihf_pkg::VERDICT_VLAN_OFF;
                t = eihf_pkg::TYPE_VLAN;
            end
            else
            begin
                t = sum_in.type_word;
                if (sum_in.kind == eihf_pkg::KIND_VLAN)
                    vid = sum_in.tag_id;
                if (active && vid == eihf_pkg::NO_VLAN)
                    vid = native_vlan[11:0];
                if (active && vid != our_vlan[11:0])
                    v = eihf_pkg::VERDICT_VLAN_MISS;
                else if (t == eihf_pkg::TYPE_IPV4)
                begin
                    need_min = {12'h0, o} + 17'd28;
                    need_tl  = {12'h0, o} + {1'b0, sum_in.total_len};
                    if ({1'b0, sum_in.len} < need_min)
                        v = eihf_pkg::VERDICT_IP_SHORT;
                    else
                    begin
                        il = sum_in.total_len;
                        if ({1'b0, sum_in.len} < need_tl)
                            v = eihf_pkg::VERDICT_IP_LEN;
                        else if (sum_in.ver_len[7:4] != 4'h4)
                            v = eihf_pkg::VERDICT_NOT_V4;
                        else if (sum_in.ver_len[3:0] > 4'h5)
                            v = eihf_pkg::VERDICT_OPTIONS;
                        else if (!sum_in.sum_good)
                            v = eihf_pkg::VERDICT_BAD_SUM;
                        else
                            v = eihf_pkg::VERDICT_IP_OK;
                    end
                end
            end
        end
    end

    assign do_pop = pop && !empty;
    assign empty = cnt_reg == '0;
    // Leave room for the item in the front register and one on the way
    assign almost_full = cnt_reg >= (AW+1)'(DEPTH - 2);
    assign {verdict, ether_type, vlan_number, payload_offset, ip_length} = mem_reg[rd_reg];

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (sum_valid)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            if (sum_valid && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!sum_valid && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Store the result item
    always_ff @(posedge clk)
    begin
        if (sum_valid)
            mem_reg[wr_reg] <= {v, t, vid, o, il};
    end

endmodule

// ----- src/ethernet_ipv4_header_filter.sv -----
// Top level of the Ethernet/VLAN/IPv4 header filter.
// Depends on eihf_pkg, eihf_front and eihf_back.
//
//  channel   direction  handshake        payload
//  input     in         push / full      frame_byte, last_byte
//  result    out        empty / pop      verdict, ether_type, vlan_number,
//                                        payload_offset, ip_length
//  config    in         cfg_valid/ready  cfg_index, cfg_data
//
// One item a cycle while full is low; after the last item the summary is
// registered in the front part and then written into the four-entry result queue.
// full rises when the queue holds two results the output side has not taken.
// Reset sets both VLAN registers to 0xFFFF and clears the frame state.
module ethernet_ipv4_header_filter #(
    parameter int COUNT_BITS = eihf_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  verdict,
    output logic [15:0] ether_type,
    output logic [11:0] vlan_number,
    output logic [4:0]  payload_offset,
    output logic [15:0] ip_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic                 take;
    logic                 sum_valid;
    eihf_pkg::frame_sum_t sum;
    logic                 almost_full;
    logic [15:0]          our_vlan_reg;
    logic [15:0]          native_vlan_reg;

    assign cfg_ready = 1'b1;
    assign full = almost_full;
    assign take = push && !full;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            our_vlan_reg    <= 16'hFFFF;
            native_vlan_reg <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == eihf_pkg::REG_OUR_VLAN)
                our_vlan_reg <= cfg_data;
            else
                native_vlan_reg <= cfg_data;
        end
    end

    eihf_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .frame_byte(frame_byte),
        .last_byte(last_byte), .sum_valid(sum_valid), .sum_out(sum)
    );

    eihf_back u_back (
        .clk(clk), .rst_n(rst_n), .sum_valid(sum_valid), .sum_in(sum),
        .our_vlan(our_vlan_reg), .native_vlan(native_vlan_reg), .pop(pop),
        .empty(empty), .almost_full(almost_full), .verdict(verdict),
        .ether_type(ether_type), .vlan_number(vlan_number),
        .payload_offset(payload_offset), .ip_length(ip_length)
    );

    // A final item always yields a summary next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> sum_valid)
        else $error("summary missing after last item");

    // Verdict stays within its code range while shown
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> verdict <= eihf_pkg::VERDICT_BAD_SUM)
        else $error("verdict out of range");

    // Offset is one of the three header positions
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (payload_offset == 5'd14 || payload_offset == 5'd18 ||
                    payload_offset == 5'd22))
        else $error("bad payload offset");

endmodule
